>>> rtl/lcfb_pkg.sv
// ----------------------------------------------------------------------------
// lcfb_pkg
// Shared types and constants for the LED card frame builder.
// ----------------------------------------------------------------------------
package lcfb_pkg;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // header layout
    localparam int HDR_LEN   = 17;
    localparam int SUM_FROM  = 8;
    localparam int IDX_W     = 5;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [7:0]  FRAME_TYPE = 8'h68;
    localparam logic [7:0]  CARD_TYPE  = 8'h32;
    localparam logic [7:0]  CMD_GROUP  = 8'h7B;
    localparam logic [7:0]  CMD_CODE   = 8'h01;
    localparam logic [15:0] NET_EXTRA  = 16'd11;

    // one output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } beat_t;

endpackage

>>> rtl/lcfb_seq.sv
// ----------------------------------------------------------------------------
// lcfb_seq
// Item register and byte sequencer: holds one accepted item and walks its
// bytes (header, payload byte, checksum) one per cycle unless the output stalls, keeping the sum.
// ----------------------------------------------------------------------------
module lcfb_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [7:0]          card_id,
    input  logic [15:0]         payload_len,
    input  logic [7:0]          payload_byte,
    input  logic                final_byte,
    output logic                beat_valid,
    input  logic                beat_ready,
    output lcfb_pkg::beat_t     beat
);
    import lcfb_pkg::*;

    // header and data-item byte positions
    localparam logic [IDX_W-1:0] H_NET_LO  = IDX_W'(4);
    localparam logic [IDX_W-1:0] H_NET_HI  = IDX_W'(5);
    localparam logic [IDX_W-1:0] H_TYPE    = IDX_W'(8);
    localparam logic [IDX_W-1:0] H_CARD    = IDX_W'(9);
    localparam logic [IDX_W-1:0] H_ID      = IDX_W'(10);
    localparam logic [IDX_W-1:0] H_GROUP   = IDX_W'(11);
    localparam logic [IDX_W-1:0] H_CODE    = IDX_W'(12);
    localparam logic [IDX_W-1:0] H_LEN_LO  = IDX_W'(13);
    localparam logic [IDX_W-1:0] H_LEN_HI  = IDX_W'(14);
    localparam logic [IDX_W-1:0] H_SUM_LO  = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] H_SUM_HI  = IDX_W'(HDR_LEN + 1);
    localparam logic [IDX_W-1:0] H_FIRST   = IDX_W'(SUM_FROM);
    localparam logic [IDX_W-1:0] H_END     = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] D_BYTE    = IDX_W'(0);
    localparam logic [IDX_W-1:0] D_SUM_LO  = IDX_W'(1);
    localparam logic [IDX_W-1:0] D_SUM_HI  = IDX_W'(2);

    logic                 hold_reg, hold_next;
    logic                 kind_reg;
    logic [7:0]           cid_reg;
    logic [15:0]          plen_reg;
    logic [7:0]           pbyte_reg;
    logic                 fin_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [15:0]          sum_reg, sum_next;
    logic                 in_frame_reg, in_frame_next;

    logic                 emit;
    logic                 accept;
    logic                 load;
    logic [IDX_W-1:0]     last_idx;
    logic                 at_last;
    logic [15:0]          net_len;
    logic [7:0]           cur_byte;
    logic                 add_byte;
    logic                 sum_hi;

    assign net_len = plen_reg + NET_EXTRA;

    // last byte position of the held item
    always_comb
    begin
        if (kind_reg == KIND_START)
            last_idx = (plen_reg == 16'd0) ? H_SUM_HI : H_END - IDX_W'(1);
        else
            last_idx = fin_reg ? D_SUM_HI : D_BYTE;
    end

    assign emit     = hold_reg && beat_ready;
    assign at_last  = (idx_reg == last_idx);
    assign in_ready = !hold_reg || (emit && at_last);
    assign accept   = in_valid && in_ready;
    // a data item outside a frame is taken and dropped
    assign load     = accept && ((kind == KIND_START) || in_frame_reg);

    // byte select for the current position
    always_comb
    begin
        cur_byte = 8'h00;
        add_byte = 1'b0;
        sum_hi   = 1'b0;
        if (kind_reg == KIND_START)
        begin
            add_byte = (idx_reg >= H_FIRST) && (idx_reg < H_END);
            if (idx_reg < H_NET_LO)
                cur_byte = SYNC_BYTE;
            else
            begin
                case (idx_reg)
                    H_NET_LO: cur_byte = net_len[7:0];
                    H_NET_HI: cur_byte = net_len[15:8];
                    H_TYPE:   cur_byte = FRAME_TYPE;
                    H_CARD:   cur_byte = CARD_TYPE;
                    H_ID:     cur_byte = cid_reg;
                    H_GROUP:  cur_byte = CMD_GROUP;
                    H_CODE:   cur_byte = CMD_CODE;
                    H_LEN_LO: cur_byte = plen_reg[7:0];
                    H_LEN_HI: cur_byte = plen_reg[15:8];
                    H_SUM_LO: cur_byte = sum_reg[7:0];
                    H_SUM_HI:
                    begin
                        cur_byte = sum_reg[15:8];
                        sum_hi   = 1'b1;
                    end
                    default:  cur_byte = 8'h00;
                endcase
            end
        end
        else
        begin
            case (idx_reg)
                D_BYTE:
                begin
                    cur_byte = pbyte_reg;
                    add_byte = 1'b1;
                end
                D_SUM_LO: cur_byte = sum_reg[7:0];
                D_SUM_HI:
                begin
                    cur_byte = sum_reg[15:8];
                    sum_hi   = 1'b1;
                end
                default:  cur_byte = 8'h00;
            endcase
        end
    end

    assign beat_valid     = hold_reg;
    assign beat.out_byte  = cur_byte;
    assign beat.run_last  = at_last;
    assign beat.frame_end = sum_hi;

    // frame state, tracked in item order at acceptance
    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (accept)
        begin
            if (kind == KIND_START)
                in_frame_next = (payload_len != 16'd0);
            else if (in_frame_reg)
                in_frame_next = !final_byte;
        end
    end

    // held item and byte position
    always_comb
    begin
        hold_next = hold_reg;
        idx_next  = idx_reg;
        if (emit)
            idx_next = idx_reg + IDX_W'(1);
        if (emit && at_last)
            hold_next = 1'b0;
        if (load)
        begin
            hold_next = 1'b1;
            idx_next  = '0;
        end
    end

    // running checksum, cleared by a start's first beat
    always_comb
    begin
        sum_next = sum_reg;
        if (emit)
        begin
            if ((kind_reg == KIND_START) && (idx_reg == '0))
                sum_next = 16'd0;
            else if (add_byte)
                sum_next = sum_reg + {8'h00, cur_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            idx_reg      <= '0;
            sum_reg      <= 16'd0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            hold_reg     <= hold_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            in_frame_reg <= in_frame_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind;
            cid_reg   <= card_id;
            plen_reg  <= payload_len;
            pbyte_reg <= payload_byte;
            fin_reg   <= final_byte;
        end
    end

endmodule

>>> rtl/lcfb_out_reg.sv
// ----------------------------------------------------------------------------
// lcfb_out_reg
// Output register: holds one beat toward the sink; the sequencer is stalled
// while a held beat waits on a sink that is not ready.
// ----------------------------------------------------------------------------
module lcfb_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat_valid,
    output logic                beat_ready,
    input  lcfb_pkg::beat_t     beat,
    output logic                out_valid,
    input  logic                out_ready,
    output lcfb_pkg::beat_t     out_beat
);
    import lcfb_pkg::*;

    logic   valid_reg, valid_next;
    beat_t  beat_reg;

    assign beat_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (beat_ready)
            valid_next = beat_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (beat_ready && beat_valid)
            beat_reg <= beat;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> rtl/led_card_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// led_card_frame_builder_unit
// LED display-card frame builder: header, payload pass-through, checksum.
// ----------------------------------------------------------------------------
// Pipeline: items are held in the sequencer, beats in the output register.
// Throughput: one output beat per cycle while out_ready is high; a data
//   item gives 1 byte (3 when final), a start 17 bytes (19 with empty
//   payload); the next item is taken as the current one's last byte goes.
// Reset: rst_n asynchronous, active low; clears frame state, sum and valids.
// ----------------------------------------------------------------------------
module led_card_frame_builder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  card_id,
    input  logic [15:0] payload_len,
    input  logic [7:0]  payload_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        frame_end
);
    import lcfb_pkg::*;

    logic   beat_valid;
    logic   beat_ready;
    beat_t  beat;
    beat_t  out_beat;

    lcfb_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .card_id      (card_id),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .final_byte   (final_byte),
        .beat_valid   (beat_valid),
        .beat_ready   (beat_ready),
        .beat         (beat)
    );

    lcfb_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat)
    );

    assign out_byte  = out_beat.out_byte;
    assign run_last  = out_beat.run_last;
    assign frame_end = out_beat.frame_end;

    // checksum high byte always closes the item's run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame_end without run_last");

    // a beat offered by the sequencer and stalled stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && !beat_ready |=> beat_valid && $stable(beat))
        else $error("stalled beat changed");

    // a new item is only taken when the sequencer is free or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && beat_valid |-> beat_ready && beat.run_last)
        else $error("input taken while item still in progress");

endmodule
